### sv/etb_pkg.sv
// Shared types and constants for the echo-then-biquad audio effect.
`default_nettype none
package etb_pkg;
   localparam int SampleW = 24;
   localparam int CoefW = 16;
   localparam int AccW = 64;
   localparam int FeedGain = 1;
   // divider width: filter sum stays below 2^(41 + log2 FeedGain)
   localparam int QuotW = 42 + $clog2(FeedGain);
   // echo divide by 800: drop 5 bits, then multiply by ceil(2^34 / 25) and drop 34 bits
   localparam int EchoShift = 5;
   localparam int EchoRecShift = 34;
   localparam logic signed [31:0] EchoRecip = 32'sd687194768;
   localparam logic signed [SampleW-1:0] SatMax = 24'sh7FFFFF;
   localparam logic signed [SampleW-1:0] SatMin = 24'sh800000;

   localparam logic [2:0] RegEnable = 3'd0;
   localparam logic [2:0] RegLevel = 3'd1;
   localparam logic [2:0] RegA0 = 3'd2;
   localparam logic [2:0] RegA1 = 3'd3;
   localparam logic [2:0] RegA2 = 3'd4;
   localparam logic [2:0] RegB0 = 3'd5;
   localparam logic [2:0] RegB1 = 3'd6;
   localparam logic [2:0] RegB2 = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ECHO_MUL, ST_ECHO_REC, ST_ECHO_SAT,
      ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F_ACC, ST_F_START, ST_F_DIV, ST_F_SAT, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic signed [AccW-1:0] dividend;
      logic signed [AccW-1:0] divisor;
   } div_req_type;

   function automatic logic signed [SampleW-1:0] sat24(input logic signed [AccW-1:0] v);
      logic signed [AccW-1:0] hi, lo;
      hi = AccW'(SatMax);
      lo = AccW'(SatMin);
      if (v > hi) return SatMax;
      if (v < lo) return SatMin;
      return v[SampleW-1:0];
   endfunction
endpackage
`default_nettype wire

### sv/echo_then_biquad_audio_effect.sv
// Top level: registers, sample history and the multiply-accumulate sequencer.
//
// One sample in, one sample out. All products go through one shared 32x32
// multiplier, one per cycle. The echo stage forms level times taps, then a
// reciprocal multiply for the divide by 800, then saturation. The filter stage
// forms five products, accumulates and loads the divider, runs a serial
// divider for the divide by 4*norm_coef, and saturates. The block takes no new
// sample until the result has been transferred out.
`default_nettype none
module echo_then_biquad_audio_effect (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic signed [23:0] req_sample_in,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic signed [23:0] rsp_sample_out,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [2:0] csr_index,
   input  wire logic [15:0] csr_data
);
   import etb_pkg::*;

   logic [1:0] en_ff;
   logic [6:0] lvl_ff;
   logic signed [CoefW-1:0] a0_ff, a1_ff, a2_ff, b1_ff, b2_ff;
   logic [14:0] b0_ff;
   logic signed [SampleW-1:0] eh0_ff, eh1_ff, eh2_ff, fi0_ff, fi1_ff, fo0_ff, fo1_ff;
   logic signed [SampleW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [AccW-1:0] acc_ff, acc_in, prod_ff, mul_p;
   logic signed [31:0] mul_a, mul_b, taps;
   logic echo_neg_ff, echo_neg_in;
   logic [AccW-1:0] echo_mag, echo_quo;
   logic signed [AccW-1:0] echo_add;
   logic [AccW-1:0] div_den;
   state_type state_ff, state_in;
   div_req_type dreq;
   logic dbusy;
   logic signed [AccW-1:0] dquot;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_sample_out = y_ff;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= '0; lvl_ff <= '0; a0_ff <= 16'sd1; a1_ff <= '0; a2_ff <= '0;
         b0_ff <= 15'd1; b1_ff <= '0; b2_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            RegEnable: en_ff <= csr_data[1:0];
            RegLevel: lvl_ff <= csr_data[6:0];
            RegA0: a0_ff <= csr_data;
            RegA1: a1_ff <= csr_data;
            RegA2: a2_ff <= csr_data;
            RegB0: b0_ff <= csr_data[14:0];
            RegB1: b1_ff <= csr_data;
            RegB2: b2_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = en_ff[0] ? ST_ECHO_MUL :
                                          (en_ff[1] ? ST_F0 : ST_OUT);
         ST_ECHO_MUL: state_in = ST_ECHO_REC;
         ST_ECHO_REC: state_in = ST_ECHO_SAT;
         ST_ECHO_SAT: state_in = en_ff[1] ? ST_F0 : ST_OUT;
         ST_F0: state_in = ST_F1;
         ST_F1: state_in = ST_F2;
         ST_F2: state_in = ST_F3;
         ST_F3: state_in = ST_F4;
         ST_F4: state_in = ST_F_ACC;
         ST_F_ACC: state_in = ST_F_START;
         ST_F_START: state_in = ST_F_DIV;
         ST_F_DIV: if (!dbusy) state_in = ST_F_SAT;
         ST_F_SAT: state_in = ST_OUT;
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign taps = (32'(eh0_ff) <<< 2) + (32'(eh1_ff) <<< 1) + 32'(eh2_ff);
   assign div_den = (b0_ff == '0) ? AccW'(4) : AccW'({b0_ff, 2'b00});

   // magnitude of level times taps, and the quotient by 800 after the reciprocal multiply
   assign echo_mag = prod_ff[AccW-1] ? AccW'(-prod_ff) : AccW'(prod_ff);
   assign echo_quo = AccW'(prod_ff[AccW-1:EchoRecShift]);
   assign echo_add = echo_neg_ff ? -signed'(echo_quo) : signed'(echo_quo);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_ECHO_MUL: begin mul_a = 32'(lvl_ff); mul_b = taps; end
         ST_ECHO_REC: begin
            mul_a = 32'(echo_mag[EchoRecShift-1:EchoShift]);
            mul_b = EchoRecip;
         end
         ST_F0: begin mul_a = 32'(a0_ff) * FeedGain; mul_b = 32'(x_ff); end
         ST_F1: begin mul_a = 32'(a1_ff) * FeedGain; mul_b = 32'(fi0_ff); end
         ST_F2: begin mul_a = 32'(a2_ff) * FeedGain; mul_b = 32'(fi1_ff); end
         ST_F3: begin mul_a = 32'(b1_ff); mul_b = 32'(fo0_ff); end
         ST_F4: begin mul_a = 32'(b2_ff); mul_b = 32'(fo1_ff); end
         default: ;
      endcase
   end

   // signed 32x32 product on sign-extended operands
   assign mul_p = AccW'(mul_a) * AccW'(mul_b);

   // datapath and divider control
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      acc_in = acc_ff;
      echo_neg_in = echo_neg_ff;
      dreq.start = 1'b0;
      dreq.dividend = acc_ff;
      dreq.divisor = signed'(div_den);
      case (state_ff)
         ST_IDLE: begin x_in = req_sample_in; y_in = req_sample_in; end
         ST_ECHO_REC: echo_neg_in = prod_ff[AccW-1];
         ST_ECHO_SAT: begin
            x_in = sat24(AccW'(x_ff) + echo_add);
            y_in = x_in;
         end
         ST_F1: acc_in = prod_ff;
         ST_F2, ST_F3: acc_in = acc_ff + prod_ff;
         ST_F4, ST_F_ACC: acc_in = acc_ff - prod_ff;
         ST_F_START: dreq.start = 1'b1;
         ST_F_SAT: y_in = sat24(dquot);
         default: ;
      endcase
   end

   // advance datapath registers and state
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      x_ff <= x_in;
      y_ff <= y_in;
      acc_ff <= acc_in;
      echo_neg_ff <= echo_neg_in;
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   etb_div u_div (
      .clock(clock), .reset(reset), .req(dreq), .busy(dbusy), .quot(dquot)
   );

   // shift histories when each stage finishes
   always_ff @(posedge clock) begin
      if (reset) begin
         eh0_ff <= '0; eh1_ff <= '0; eh2_ff <= '0;
         fi0_ff <= '0; fi1_ff <= '0; fo0_ff <= '0; fo1_ff <= '0;
      end else begin
         if (state_ff == ST_ECHO_SAT) begin
            eh2_ff <= eh1_ff; eh1_ff <= eh0_ff; eh0_ff <= x_ff;
         end
         if (state_ff == ST_F_SAT) begin
            fi1_ff <= fi0_ff; fi0_ff <= x_ff;
            fo1_ff <= fo0_ff; fo0_ff <= y_in;
         end
      end
   end
endmodule
`default_nettype wire

### sv/etb_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module etb_div (
   input  wire logic clock,
   input  wire logic reset,
   input  wire etb_pkg::div_req_type req,
   output logic busy,
   output logic signed [etb_pkg::AccW-1:0] quot
);
   import etb_pkg::*;
   localparam int CntW = $clog2(QuotW + 1);

   logic [QuotW-1:0] q_ff, q_in;
   logic [QuotW:0] rem_ff, rem_in;
   logic [QuotW-1:0] den_ff, den_in;
   logic neg_ff, neg_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [AccW-1:0] num_mag, den_mag;
   logic [QuotW:0] trial;

   always_comb begin
      num_mag = req.dividend[AccW-1] ? AccW'(-req.dividend) : req.dividend;
      den_mag = req.divisor[AccW-1] ? AccW'(-req.divisor) : req.divisor;
      trial = {rem_ff[QuotW-1:0], q_ff[QuotW-1]};
      q_in = q_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      // load operands
      if (req.start) begin
         q_in = num_mag[QuotW-1:0];
         rem_in = '0;
         den_in = den_mag[QuotW-1:0];
         neg_in = req.dividend[AccW-1] ^ req.divisor[AccW-1];
         cnt_in = CntW'(QuotW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one bit and try subtract
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in = {q_ff[QuotW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[QuotW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign quot = neg_ff ? -AccW'(q_ff) : AccW'(q_ff);
endmodule
`default_nettype wire

### sv/etb_checker.sv
// Port-level checker for the echo-then-biquad audio effect, bound to the top level.
`default_nettype none
module etb_port_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic signed [23:0] rsp_sample_out
);
   a_no_take_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken while result pending");
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
      else $error("result dropped or changed");
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after transfer");
   a_idle_after_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid) else $error("result repeated");
endmodule
bind echo_then_biquad_audio_effect etb_port_checker u_chk (.*);
`default_nettype wire

### tb/etb_checker.sv
// Scoreboard for the echo-then-biquad effect: predicts every sample and compares.
`timescale 1ns / 100ps
module etb_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_ready,
   input  wire logic signed [23:0] req_sample_in,
   input  wire logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire logic signed [23:0] rsp_sample_out,
   input  wire logic csr_valid,
   input  wire logic csr_ready,
   input  wire logic [2:0] csr_index,
   input  wire logic [15:0] csr_data,
   output int fail_count,
   output int pending_count,
   output int sample_count
);
   import etb_pkg::*;

   // shadow registers
   logic [1:0] enable_q;
   logic [6:0] level_q;
   logic signed [15:0] a0_q, a1_q, a2_q, b1_q, b2_q;
   logic [14:0] b0_q;
   // shadow history
   logic signed [23:0] echo_hist [3];
   logic signed [23:0] fin_hist [2];
   logic signed [23:0] fout_hist [2];
   logic signed [23:0] sample_queue [$];

   function automatic logic signed [23:0] clip24(input longint v);
      if (v > 64'sd8388607) return 24'sh7FFFFF;
      if (v < -64'sd8388608) return 24'sh800000;
      return v[23:0];
   endfunction

   // advance the shadow state by one sample and return the processed value
   function automatic logic signed [23:0] process_sample(input logic signed [23:0] x_in);
      longint taps, acc, div;
      logic signed [23:0] x, y;
      x = x_in;
      if (enable_q[0]) begin
         taps = 4 * longint'(echo_hist[0]) + 2 * longint'(echo_hist[1])
                + longint'(echo_hist[2]);
         y = clip24(longint'(x) + (longint'(level_q) * taps) / 800);
         echo_hist[2] = echo_hist[1];
         echo_hist[1] = echo_hist[0];
         echo_hist[0] = x;
         x = y;
      end
      if (enable_q[1]) begin
         acc = longint'(FeedGain) * (longint'(a0_q) * x + longint'(a1_q) * fin_hist[0]
               + longint'(a2_q) * fin_hist[1])
               - longint'(b1_q) * fout_hist[0] - longint'(b2_q) * fout_hist[1];
         div = 4 * ((b0_q == 0) ? 1 : longint'(b0_q));
         y = clip24(acc / div);
         fin_hist[1] = fin_hist[0];
         fin_hist[0] = x;
         fout_hist[1] = fout_hist[0];
         fout_hist[0] = y;
         x = y;
      end
      return x;
   endfunction

   assign pending_count = sample_queue.size();

   always @(posedge clock) begin
      logic signed [23:0] want;
      if (reset) begin
         enable_q <= 0; level_q <= 0;
         a0_q <= 1; a1_q <= 0; a2_q <= 0; b0_q <= 1; b1_q <= 0; b2_q <= 0;
         echo_hist = '{0, 0, 0};
         fin_hist = '{0, 0};
         fout_hist = '{0, 0};
         sample_queue.delete();
         fail_count <= 0;
         sample_count <= 0;
      end else begin
         // check the output transfer
         if (rsp_valid && rsp_ready) begin
            sample_count <= sample_count + 1;
            if (sample_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected sample_out %0d", $realtime, rsp_sample_out);
               fail_count <= fail_count + 1;
            end else begin
               want = sample_queue.pop_front();
               if (want !== rsp_sample_out) begin
                  if (fail_count < 10)
                     $display("%0t: sample_out expected %0d got %0d", $realtime, want,
                              rsp_sample_out);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // predict from the input transfer
         if (req_valid && req_ready)
            sample_queue.push_back(process_sample(req_sample_in));
         // track register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               RegEnable: enable_q <= csr_data[1:0];
               RegLevel: level_q <= csr_data[6:0];
               RegA0: a0_q <= csr_data;
               RegA1: a1_q <= csr_data;
               RegA2: a2_q <= csr_data;
               RegB0: b0_q <= csr_data[14:0];
               RegB1: b1_q <= csr_data;
               RegB2: b2_q <= csr_data;
               default: ;
            endcase
         end
      end
   end
endmodule

### tb/testbench.sv
// Top of the echo-then-biquad testbench: stimulus, register phases and verdict.
`timescale 1ns / 100ps
module testbench;
   import etb_pkg::*;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0, csr_valid = 0;
   logic signed [23:0] req_sample_in = 0;
   logic [2:0] csr_index = 0;
   logic [15:0] csr_data = 0;
   wire logic req_ready, rsp_valid, csr_ready;
   wire logic signed [23:0] rsp_sample_out;
   int fail_count, pending_count, sample_count;
   int cycle_count = 0;
   int sent_count = 0;
   bit stim_done = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   echo_then_biquad_audio_effect u_dut (.*);

   etb_checker u_checker (.*);

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // output side: hold ready low for a drawn number of cycles before each transfer
   initial begin : rsp_side
      int stall;
      @(negedge clock);
      forever begin
         stall = $urandom_range(0, 17);
         if (stall != 0) begin
            rsp_ready <= 0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (reset || !rsp_valid);
         @(negedge clock);
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic send_sample(input logic signed [23:0] s, input int gap);
      repeat (gap) @(negedge clock);
      @(negedge clock);
      req_sample_in <= s;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      @(negedge clock);
      req_valid <= 0;
   endtask

   // let the block drain before touching registers
   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic signed [23:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return $signed(24'($urandom_range(0, 2000))) - 24'sd1000;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 64)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_setting();
      write_reg(RegEnable, 16'($urandom_range(0, 3)));
      write_reg(RegLevel, 16'($urandom_range(0, 127)));
      write_reg(RegA0, pick_coef());
      write_reg(RegA1, pick_coef());
      write_reg(RegA2, pick_coef());
      write_reg(RegB0, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 2))
                                                  : 16'($urandom));
      // feedback kept small most of the time so the filter does not pin
      write_reg(RegB1, ($urandom_range(0, 2) == 0) ? pick_coef()
                                                  : 16'($urandom_range(0, 4)) - 16'd2);
      write_reg(RegB2, ($urandom_range(0, 2) == 0) ? pick_coef()
                                                  : 16'($urandom_range(0, 4)) - 16'd2);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: bypass, echo only at full and over-range level, extremes
      send_sample(24'sh7FFFFF, 0);
      send_sample(24'sh800000, 0);
      drain();
      write_reg(RegEnable, 16'd1);
      write_reg(RegLevel, 16'd100);
      send_sample(24'sh7FFFFF, 0);
      send_sample(24'sh7FFFFF, 1);
      send_sample(24'sh7FFFFF, 0);
      send_sample(24'sh800000, 0);
      drain();
      write_reg(RegLevel, 16'd127);
      send_sample(24'sh800000, 0);
      send_sample(24'sh800000, 0);
      send_sample(-24'sd1, 0);
      drain();
      // filter with zero norm and extreme coefficients
      write_reg(RegEnable, 16'd2);
      write_reg(RegB0, 16'd0);
      write_reg(RegA0, 16'h7FFF);
      write_reg(RegA1, 16'h8000);
      write_reg(RegA2, 16'h7FFF);
      write_reg(RegB1, 16'h8000);
      write_reg(RegB2, 16'h7FFF);
      send_sample(24'sh7FFFFF, 0);
      send_sample(24'sh800000, 0);
      send_sample(24'sd0, 0);
      send_sample(24'sd12345, 0);
      drain();
      write_reg(RegEnable, 16'd3);
      write_reg(RegB0, 16'h7FFF);
      send_sample(24'sh7FFFFF, 0);
      send_sample(24'sh800000, 0);
      send_sample(24'sd777, 0);
      drain();
      write_reg(RegEnable, 16'd0);
      // random phases
      while (sent_count < 1020) begin
         random_setting();
         repeat ($urandom_range(30, 120))
            send_sample(pick_sample(), ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
         drain();
      end
      stim_done = 1;
   end

   // verdict once all stimulus has drained
   initial begin
      wait (stim_done);
      $display("Sent %0d samples through bypass, echo, biquad and combined settings;",
               sent_count);
      $display("checked %0d output samples against the shadow model.", sample_count);
      if (fail_count == 0 && pending_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
